// ===== src/srw_pkg.sv =====
// package for the sender retransmit window unit
// types, constants and operation codes shared by front, back and top
`timescale 1ns / 1ps
package srw_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam logic [15:0] RESET_TIMEOUT = 16'd1000;
  localparam logic [4:0]  RESET_WLIMIT  = 5'd16;
  localparam logic [7:0]  RESET_RLIMIT  = 8'd5;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_ACK     = 3'd1,
    OP_TICK    = 3'd2,
    OP_RETX    = 3'd3,
    OP_RESTART = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_BASE    = 2'd0,
    CFG_WLIMIT  = 2'd1,
    CFG_RLIMIT  = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_t;

  // classified command between front and back
  typedef struct packed {
    logic [2:0]  op;
    logic        known;
    logic [31:0] seq;
    logic [31:0] upto;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FIN
  } st_t;

endpackage

// ===== src/srw_front.sv =====
// front end: accepts transfers, classifies the operation, feeds a two-entry queue
// depends on srw_pkg
`timescale 1ns / 1ps
module srw_front
  import srw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_seq_in,
  input  logic [31:0] in_ack_number,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cmd.op    = in_operation;
    cmd.known = (in_operation <= OP_RESTART);
    cmd.seq   = in_seq_in;
    cmd.upto  = in_ack_number - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/srw_back.sv =====
// back end: slot store, timer and sequencer that scans slots one per cycle
// depends on srw_pkg
`timescale 1ns / 1ps
module srw_back
  import srw_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_seq_out,
  output logic        out_retry_failed,
  output logic        out_timed_out,
  output logic [31:0] out_window_base,
  output logic [4:0]  out_occupancy,
  output logic        out_last
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] done_r, done_nxt;
  logic [31:0] seq_r [SLOTS];
  logic [7:0]  rty_r [SLOTS];
  logic [CW-1:0] occ_r, occ_nxt;
  logic [31:0] base_r, base_nxt;
  logic        run_r, run_nxt;
  logic [15:0] el_r, el_nxt;
  logic [4:0]  wlim_r;
  logic [7:0]  rlim_r;
  logic [15:0] tmo_r;

  st_t st_r, st_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic          have_r, have_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic          hasfree_r, hasfree_nxt;
  logic          dup_r, dup_nxt;
  logic          rem_r, rem_nxt;
  logic          any_r, any_nxt;
  logic [31:0]   low_r, low_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;

  logic        ov_r, ov_nxt;
  logic        ook_r, ook_nxt;
  logic [31:0] oseq_r, oseq_nxt;
  logic        ofail_r, ofail_nxt;
  logic        olast_r, olast_nxt;
  logic        otout_r, otout_nxt;
  logic [31:0] obase_r, obase_nxt;
  logic [4:0]  oocc_r, oocc_nxt;
  logic        ocapture;

  logic        wr_add, bump;
  logic [IW-1:0] wr_idx;
  logic        last_idx;
  logic [CW-1:0] lim;
  logic        out_free;
  logic        cont;

  assign out_free = !ov_r || out_ready;
  assign last_idx = (idx_r == IW'(SLOTS - 1));
  assign lim = ({27'd0, wlim_r} > 32'(SLOTS)) ? CW'(SLOTS) : CW'(wlim_r);

  // emit pass continues: go back to scanning without taking a new command
  assign cont = (st_r == ST_EMIT) && out_free && bump && !olast_nxt;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = (q_cmd.op == OP_ADD || q_cmd.op == OP_ACK ||
                                     q_cmd.op == OP_RETX) && q_cmd.known ?
                                     ST_SCAN : ST_FIN;
      ST_SCAN: if (last_idx) st_nxt = (cmd_r.op == OP_RETX) ? ST_EMIT : ST_FIN;
      ST_EMIT: if (out_free) st_nxt = cont ? ST_SCAN : ST_IDLE;
      ST_FIN:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_ready     = (st_r == ST_IDLE);
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    pick_nxt    = pick_r;
    have_nxt    = have_r;
    free_nxt    = free_r;
    hasfree_nxt = hasfree_r;
    dup_nxt     = dup_r;
    rem_nxt     = rem_r;
    any_nxt     = any_r;
    low_nxt     = low_r;
    done_nxt    = done_r;
    emitted_nxt = emitted_r;
    valid_nxt   = valid_r;
    occ_nxt     = occ_r;
    base_nxt    = base_r;
    run_nxt     = run_r;
    el_nxt      = el_r;
    ov_nxt      = ov_r && !out_ready;
    ook_nxt     = ook_r;
    oseq_nxt    = oseq_r;
    ofail_nxt   = ofail_r;
    olast_nxt   = olast_r;
    otout_nxt   = otout_r;
    obase_nxt   = obase_r;
    oocc_nxt    = oocc_r;
    ocapture    = 1'b0;
    wr_add      = 1'b0;
    bump        = 1'b0;
    wr_idx      = free_r;
    if (cfg_we && cfg_index == CFG_BASE) base_nxt = cfg_data;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt     = q_cmd;
          idx_nxt     = '0;
          have_nxt    = 1'b0;
          hasfree_nxt = 1'b0;
          dup_nxt     = 1'b0;
          rem_nxt     = 1'b0;
          any_nxt     = 1'b0;
          if (q_cmd.op == OP_RETX && q_cmd.known && emitted_r == '0) done_nxt = '0;
        end
      end
      ST_SCAN: begin
        idx_nxt = last_idx ? '0 : idx_r + IW'(1);
        if (cmd_r.op == OP_ADD) begin
          if (valid_r[idx_r]) begin
            if (seq_r[idx_r] == cmd_r.seq) dup_nxt = 1'b1;
          end else if (!hasfree_r) begin
            hasfree_nxt = 1'b1;
            free_nxt    = idx_r;
          end
        end else if (cmd_r.op == OP_ACK) begin
          if (valid_r[idx_r]) begin
            if (seq_r[idx_r] <= cmd_r.upto) begin
              valid_nxt[idx_r] = 1'b0;
              occ_nxt = occ_nxt - CW'(1);
              rem_nxt = 1'b1;
            end else if (!any_r || seq_r[idx_r] < low_r) begin
              any_nxt = 1'b1;
              low_nxt = seq_r[idx_r];
            end
          end
        end else begin
          if (valid_r[idx_r] && !done_r[idx_r] &&
              (!have_r || seq_r[idx_r] < seq_r[pick_r])) begin
            have_nxt = 1'b1;
            pick_nxt = idx_r;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ocapture = 1'b1;
          if (!have_r) begin
            ook_nxt = 1'b0; oseq_nxt = '0; ofail_nxt = 1'b0;
            olast_nxt = 1'b1;
            emitted_nxt = '0;
          end else if (rty_r[pick_r] >= rlim_r) begin
            ook_nxt = 1'b0; oseq_nxt = seq_r[pick_r]; ofail_nxt = 1'b1;
            olast_nxt = 1'b1;
            emitted_nxt = '0;
          end else begin
            bump = 1'b1;
            done_nxt[pick_r] = 1'b1;
            ook_nxt = 1'b1; oseq_nxt = seq_r[pick_r]; ofail_nxt = 1'b0;
            olast_nxt = (emitted_r + CW'(1) == occ_r);
            emitted_nxt = olast_nxt ? '0 : emitted_r + CW'(1);
            // next candidate comes from a fresh scan of the slots
            if (!olast_nxt) begin
              idx_nxt  = '0;
              have_nxt = 1'b0;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ocapture  = 1'b1;
          ook_nxt   = 1'b0;
          oseq_nxt  = '0;
          ofail_nxt = 1'b0;
          olast_nxt = 1'b1;
          if (cmd_r.known) begin
            case (cmd_r.op)
              OP_ADD: begin
                if (occ_r < lim && !dup_r && hasfree_r) begin
                  ook_nxt = 1'b1;
                  wr_add  = 1'b1;
                  valid_nxt[free_r] = 1'b1;
                  occ_nxt = occ_r + CW'(1);
                  if (!run_r) begin
                    run_nxt = 1'b1;
                    el_nxt  = '0;
                  end
                end
              end
              OP_ACK: begin
                if (occ_r != '0 || rem_r) begin
                  ook_nxt = rem_r;
                  el_nxt  = '0;
                  run_nxt = any_r;
                  base_nxt = any_r ? low_r : cmd_r.upto + 32'd1;
                end
              end
              OP_TICK: begin
                if (run_r && el_r != 16'hFFFF) el_nxt = el_r + 16'd1;
              end
              OP_RESTART: begin
                if (run_r) begin
                  ook_nxt = 1'b1;
                  el_nxt  = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    // status fields reflect the state after the operation and stay with the result
    if (ocapture) begin
      ov_nxt    = 1'b1;
      otout_nxt = run_nxt && (el_nxt >= tmo_r);
      obase_nxt = base_nxt;
      oocc_nxt  = 5'(occ_nxt);
    end
  end

  assign out_valid        = ov_r;
  assign out_ok           = ook_r;
  assign out_seq_out      = oseq_r;
  assign out_retry_failed = ofail_r;
  assign out_last         = olast_r;
  assign out_timed_out    = otout_r;
  assign out_window_base  = obase_r;
  assign out_occupancy    = oocc_r;

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    pick_r    <= pick_nxt;
    have_r    <= have_nxt;
    free_r    <= free_nxt;
    hasfree_r <= hasfree_nxt;
    dup_r     <= dup_nxt;
    rem_r     <= rem_nxt;
    any_r     <= any_nxt;
    low_r     <= low_nxt;
    done_r    <= done_nxt;
    ook_r     <= ook_nxt;
    oseq_r    <= oseq_nxt;
    ofail_r   <= ofail_nxt;
    olast_r   <= olast_nxt;
    otout_r   <= otout_nxt;
    obase_r   <= obase_nxt;
    oocc_r    <= oocc_nxt;
    if (wr_add) begin
      seq_r[wr_idx] <= cmd_r.seq;
      rty_r[wr_idx] <= 8'd0;
    end
    if (bump) rty_r[pick_r] <= rty_r[pick_r] + 8'd1;
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      valid_r   <= '0;
      occ_r     <= '0;
      base_r    <= '0;
      run_r     <= 1'b0;
      el_r      <= '0;
      ov_r      <= 1'b0;
      emitted_r <= '0;
      wlim_r    <= RESET_WLIMIT;
      rlim_r    <= RESET_RLIMIT;
      tmo_r     <= RESET_TIMEOUT;
    end else begin
      st_r      <= st_nxt;
      valid_r   <= valid_nxt;
      occ_r     <= occ_nxt;
      base_r    <= base_nxt;
      run_r     <= run_nxt;
      el_r      <= el_nxt;
      ov_r      <= ov_nxt;
      emitted_r <= emitted_nxt;
      if (cfg_we && cfg_index == CFG_WLIMIT)  wlim_r <= cfg_data[4:0];
      if (cfg_we && cfg_index == CFG_RLIMIT)  rlim_r <= cfg_data[7:0];
      if (cfg_we && cfg_index == CFG_TIMEOUT) tmo_r  <= cfg_data[15:0];
    end
  end

endmodule

// ===== src/sender_retransmit_window_unit.sv =====
// top level of the sender retransmit window unit
// joins srw_front (intake queue) and srw_back (slot store and sequencer); uses srw_pkg
//
// channel   | handshake            | payload
// in        | in_valid / in_ready  | operation, seq_in, ack_number
// out       | out_valid / out_ready| ok, seq_out, retry_failed, timed_out, window_base,
//           |                      | occupancy, last
// cfg       | cfg_we               | cfg_index, cfg_data
//
// add and ack wait for the back end to scan every slot, one slot per cycle, before the result
// tick, restart and unused codes skip the scan; each retransmit result costs a scan
// of all slots, so a full listing costs about one scan per occupied slot
// synchronous reset; the front queue takes up to two transfers while the back end
// works or the result register is held by out_ready low
`timescale 1ns / 1ps
module sender_retransmit_window_unit
  import srw_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_seq_in,
  input  logic [31:0] in_ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_seq_out,
  output logic        out_retry_failed,
  output logic        out_timed_out,
  output logic [31:0] out_window_base,
  output logic [4:0]  out_occupancy,
  output logic        out_last
);

  logic q_valid, q_ready;
  cmd_t q_cmd;

  srw_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_seq_in, .in_ack_number,
    .q_valid, .q_ready, .q_cmd
  );

  srw_back #(.SLOTS(WINDOW_SLOTS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_ok, .out_seq_out, .out_retry_failed,
    .out_timed_out, .out_window_base, .out_occupancy, .out_last
  );

endmodule
